// ===== sv/x86_64_subset_instruction_encoder_defines.svh =====
// Assertion helpers shared by the encoder RTL.
`ifndef X86_64_SUBSET_INSTRUCTION_ENCODER_DEFINES_SVH
`define X86_64_SUBSET_INSTRUCTION_ENCODER_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define X64E_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define X64E_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/x64e_pkg.sv =====
package x64e_pkg;

  // Mnemonic and operand form codes of an input beat
  typedef enum logic [2:0] {
    FN_MOV  = 3'd0,
    FN_ADD  = 3'd1,
    FN_SUB  = 3'd2,
    FN_JMP  = 3'd3,
    FN_CMP  = 3'd4,
    FN_JE   = 3'd5,
    FN_CALL = 3'd6,
    FN_RET  = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    FM_REG_REG = 2'd0,
    FM_REG_IMM = 2'd1,
    FM_REG_MEM = 2'd2,
    FM_MEM_REG = 2'd3
  } form_e;

  // Longest encoding in bytes and the width of a byte count
  localparam int unsigned MaxBytes = 10;
  localparam int unsigned ByteCntW = 4;
  localparam int unsigned EncW     = MaxBytes * 8;

  // Opcode bytes
  localparam logic [7:0] RexBase    = 8'h40;
  localparam logic [7:0] RexW       = 8'h08;
  localparam logic [7:0] OpMovImm   = 8'hB8;
  localparam logic [7:0] OpMovStore = 8'h89;
  localparam logic [7:0] OpMovLoad  = 8'h8B;
  localparam logic [7:0] OpAluImm   = 8'h81;
  localparam logic [7:0] OpAdd      = 8'h01;
  localparam logic [7:0] OpSub      = 8'h29;
  localparam logic [7:0] OpJmp      = 8'hE9;
  localparam logic [7:0] OpCall     = 8'hE8;
  localparam logic [7:0] OpJccEsc   = 8'h0F;
  localparam logic [7:0] OpJe       = 8'h84;
  localparam logic [7:0] OpRet      = 8'hC3;

  // ModRM reg-field extensions of the 81 group
  localparam logic [2:0] ExtAdd = 3'd0;
  localparam logic [2:0] ExtSub = 3'd5;
  localparam logic [2:0] ExtCmp = 3'd7;

  // ModRM mod codes
  localparam logic [1:0] ModNoDisp = 2'd0;
  localparam logic [1:0] ModDisp8  = 2'd1;
  localparam logic [1:0] ModDisp32 = 2'd2;
  localparam logic [1:0] ModReg    = 2'd3;

  // Register low-bit codes with special meaning in ModRM and SIB
  localparam logic [2:0] LowSib   = 3'd4;
  localparam logic [2:0] LowRbp   = 3'd5;
  localparam logic [3:0] RegRsp   = 4'd4;

  // Lengths of the relative branch forms
  localparam logic [31:0] RelLenNear = 32'd5;
  localparam logic [31:0] RelLenJe   = 32'd6;

  // One encoded instruction: byte 0 in the low bits
  typedef struct packed {
    logic [EncW-1:0]     bytes;
    logic [ByteCntW-1:0] len;
    logic                err;
  } enc_rec_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] rex_byte(input logic r, input logic x, input logic b);
    return RexBase | RexW | {5'b00000, r, x, b};
  endfunction

  function automatic logic [7:0] modrm_byte(input logic [1:0] md, input logic [2:0] rg,
                                            input logic [2:0] rm);
    return {md, rg, rm};
  endfunction

  function automatic logic [7:0] sib_byte(input logic [1:0] sc, input logic [2:0] ix,
                                          input logic [2:0] bs);
    return {sc, ix, bs};
  endfunction

endpackage

// ===== sv/x64e_in_if.sv =====
interface x64e_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic [1:0]         form;
  logic [3:0]         reg_a;
  logic [3:0]         reg_b;
  logic               has_base;
  logic [3:0]         base_reg;
  logic               has_index;
  logic [3:0]         index_reg;
  logic [1:0]         scale_log2;
  logic signed [31:0] displacement;
  logic [63:0]        operand_value;
  logic [63:0]        current_address;

  modport source (
    output valid, func, form, reg_a, reg_b, has_base, base_reg, has_index, index_reg,
           scale_log2, displacement, operand_value, current_address,
    input  ready
  );

  modport sink (
    input  valid, func, form, reg_a, reg_b, has_base, base_reg, has_index, index_reg,
           scale_log2, displacement, operand_value, current_address,
    output ready
  );
endinterface

// ===== sv/x64e_out_if.sv =====
interface x64e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       error;

  modport source (
    output valid, out_byte, last, error,
    input  ready
  );

  modport sink (
    input  valid, out_byte, last, error,
    output ready
  );
endinterface

// ===== sv/x64e_front.sv =====
module x64e_front (
  x64e_in_if.sink            inst_if,
  input  x64e_pkg::q_stat_t  q_stat_i,
  output logic               push_o,
  output x64e_pkg::enc_rec_t push_rec_o
);
  import x64e_pkg::*;

  func_e               fn;
  form_e               fm;
  logic                mem_bad;
  logic                use_sib;
  logic                disp_zero;
  logic                disp_small;
  logic                x_bit;
  logic [1:0]          mem_mod;
  logic [7:0]          mem_op;
  logic [7:0]          rex_mem;
  logic [7:0]          modrm_mem;
  logic [7:0]          sib_b;
  logic [ByteCntW-1:0] disp_len;
  logic [ByteCntW-1:0] mem_len;
  logic [EncW-1:0]     mem_bytes;
  logic [EncW-1:0]     alu_rr_bytes;
  logic [EncW-1:0]     alu_imm_bytes;
  logic [7:0]          alu_rr_op;
  logic [2:0]          alu_ext;
  logic [31:0]         rel_adj;
  logic [31:0]         rel_off;
  logic                bad;
  enc_rec_t            rec;

  // Take a beat whenever the queue has room
  assign inst_if.ready = !q_stat_i.full;
  assign push_o        = inst_if.valid && inst_if.ready;

  assign fn = func_e'(inst_if.func);
  assign fm = form_e'(inst_if.form);

  // Classify the memory operand
  assign mem_bad    = !inst_if.has_base || (inst_if.has_index && inst_if.index_reg == RegRsp);
  assign use_sib    = inst_if.has_index || inst_if.base_reg[2:0] == LowSib;
  assign disp_zero  = inst_if.displacement == 32'sd0;
  assign disp_small = (&inst_if.displacement[31:7]) || !(|inst_if.displacement[31:7]);
  assign x_bit      = inst_if.has_index && inst_if.index_reg[3];

  always_comb begin
    if (disp_zero && inst_if.base_reg[2:0] != LowRbp) begin
      mem_mod  = ModNoDisp;
      disp_len = ByteCntW'(0);
    end else if (disp_small) begin
      mem_mod  = ModDisp8;
      disp_len = ByteCntW'(1);
    end else begin
      mem_mod  = ModDisp32;
      disp_len = ByteCntW'(4);
    end
  end

  // Assemble REX, opcode, ModRM, SIB and displacement of a memory form
  assign mem_op    = (fm == FM_REG_MEM) ? OpMovLoad : OpMovStore;
  assign rex_mem   = rex_byte(inst_if.reg_a[3], x_bit, inst_if.base_reg[3]);
  assign modrm_mem = modrm_byte(mem_mod, inst_if.reg_a[2:0],
                                use_sib ? LowSib : inst_if.base_reg[2:0]);
  assign sib_b     = sib_byte(inst_if.has_index ? inst_if.scale_log2 : 2'd0,
                              inst_if.has_index ? inst_if.index_reg[2:0] : LowSib,
                              inst_if.base_reg[2:0]);
  assign mem_bytes = use_sib
                   ? {16'h0000, inst_if.displacement, sib_b, modrm_mem, mem_op, rex_mem}
                   : {24'h000000, inst_if.displacement, modrm_mem, mem_op, rex_mem};
  assign mem_len   = ByteCntW'(3) + {{(ByteCntW-1){1'b0}}, use_sib} + disp_len;

  // Arithmetic forms
  always_comb begin
    case (fn)
      FN_ADD:  alu_ext = ExtAdd;
      FN_SUB:  alu_ext = ExtSub;
      default: alu_ext = ExtCmp;
    endcase
  end

  assign alu_rr_op     = (fn == FN_ADD) ? OpAdd : OpSub;
  assign alu_rr_bytes  = {56'h0,
                          modrm_byte(ModReg, inst_if.reg_b[2:0], inst_if.reg_a[2:0]),
                          alu_rr_op,
                          rex_byte(inst_if.reg_b[3], 1'b0, inst_if.reg_a[3])};
  assign alu_imm_bytes = {24'h0, inst_if.operand_value[31:0],
                          modrm_byte(ModReg, alu_ext, inst_if.reg_a[2:0]),
                          OpAluImm,
                          rex_byte(1'b0, 1'b0, inst_if.reg_a[3])};

  // Branch offset relative to the next instruction, low 32 bits only
  assign rel_adj = (fn == FN_JE) ? RelLenJe : RelLenNear;
  assign rel_off = inst_if.operand_value[31:0] - inst_if.current_address[31:0] - rel_adj;

  // Select the encoding
  always_comb begin
    rec       = '0;
    rec.len   = ByteCntW'(1);
    bad       = 1'b0;
    case (fn)
      FN_MOV: begin
        case (fm)
          FM_REG_REG: begin
            rec.bytes = {56'h0,
                         modrm_byte(ModReg, inst_if.reg_b[2:0], inst_if.reg_a[2:0]),
                         OpMovStore,
                         rex_byte(inst_if.reg_b[3], 1'b0, inst_if.reg_a[3])};
            rec.len   = ByteCntW'(3);
          end
          FM_REG_IMM: begin
            rec.bytes = {inst_if.operand_value,
                         OpMovImm | {5'b00000, inst_if.reg_a[2:0]},
                         rex_byte(1'b0, 1'b0, inst_if.reg_a[3])};
            rec.len   = ByteCntW'(MaxBytes);
          end
          default: begin
            rec.bytes = mem_bytes;
            rec.len   = mem_len;
            bad       = mem_bad;
          end
        endcase
      end
      FN_ADD, FN_SUB: begin
        case (fm)
          FM_REG_REG: begin
            rec.bytes = alu_rr_bytes;
            rec.len   = ByteCntW'(3);
          end
          FM_REG_IMM: begin
            rec.bytes = alu_imm_bytes;
            rec.len   = ByteCntW'(7);
          end
          default: bad = 1'b1;
        endcase
      end
      FN_CMP: begin
        rec.bytes = alu_imm_bytes;
        rec.len   = ByteCntW'(7);
        bad       = fm != FM_REG_IMM;
      end
      FN_JMP: begin
        rec.bytes = {40'h0, rel_off, OpJmp};
        rec.len   = ByteCntW'(5);
      end
      FN_CALL: begin
        rec.bytes = {40'h0, rel_off, OpCall};
        rec.len   = ByteCntW'(5);
      end
      FN_JE: begin
        rec.bytes = {32'h0, rel_off, OpJe, OpJccEsc};
        rec.len   = ByteCntW'(6);
      end
      default: begin
        rec.bytes = {72'h0, OpRet};
        rec.len   = ByteCntW'(1);
      end
    endcase
    // Collapse an unsupported operand to one zero error byte
    if (bad) begin
      rec.bytes = '0;
      rec.len   = ByteCntW'(1);
      rec.err   = 1'b1;
    end
  end

  assign push_rec_o = rec;

endmodule

// ===== sv/x64e_queue.sv =====
module x64e_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  x64e_pkg::enc_rec_t push_rec_i,
  input  logic               pop_i,
  output x64e_pkg::enc_rec_t head_o,
  output x64e_pkg::q_stat_t  stat_o
);
  import x64e_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  enc_rec_t        entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign stat_o.full  = cnt_q == CntW'(Depth);
  assign stat_o.empty = cnt_q == '0;
  assign head_o       = entry_q[rd_ptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed record
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_rec_i;
    end
  end

endmodule

// ===== sv/x64e_back.sv =====
module x64e_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  x64e_pkg::enc_rec_t head_i,
  input  x64e_pkg::q_stat_t  q_stat_i,
  output logic               pop_o,
  x64e_out_if.source         byte_if
);
  import x64e_pkg::*;

  logic [EncW-1:0]     sh_q, sh_d;
  logic [ByteCntW-1:0] rem_q, rem_d;
  logic                err_q, err_d;
  logic                ov_q, ov_d;
  logic [7:0]          ob_q, ob_d;
  logic                olast_q, olast_d;
  logic                oerr_q, oerr_d;
  logic                advance;
  logic                emit;
  logic                need_load;

  // Move a byte into the output register when it is free or being drained
  assign advance   = !ov_q || byte_if.ready;
  assign emit      = advance && rem_q != '0;
  assign need_load = (rem_q == '0) || (emit && rem_q == ByteCntW'(1));
  assign pop_o     = need_load && !q_stat_i.empty;

  always_comb begin
    rem_d   = rem_q;
    sh_d    = sh_q;
    err_d   = err_q;
    ov_d    = ov_q;
    ob_d    = ob_q;
    olast_d = olast_q;
    oerr_d  = oerr_q;
    // Drive the output beat
    if (emit) begin
      ov_d    = 1'b1;
      ob_d    = sh_q[7:0];
      olast_d = rem_q == ByteCntW'(1);
      oerr_d  = err_q;
    end else if (advance) begin
      ov_d = 1'b0;
    end
    // Load the next record or shift out the sent byte
    if (pop_o) begin
      sh_d  = head_i.bytes;
      rem_d = head_i.len;
      err_d = head_i.err;
    end else if (emit) begin
      sh_d  = sh_q >> 8;
      rem_d = rem_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      rem_q <= rem_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q    <= sh_d;
    err_q   <= err_d;
    ob_q    <= ob_d;
    olast_q <= olast_d;
    oerr_q  <= oerr_d;
  end

  assign byte_if.valid    = ov_q;
  assign byte_if.out_byte = ob_q;
  assign byte_if.last     = olast_q;
  assign byte_if.error    = oerr_q;

endmodule

// ===== sv/x86_64_subset_instruction_encoder.sv =====
// Encodes one pre-parsed x86-64 instruction per input beat (MOV, ADD, SUB, CMP, JMP, JE,
// CALL, RET) into its machine code, sent as one byte per output beat with last on the
// final byte; an unsupported operand gives a single zero byte with error and last set.
// An instruction has 1 to 10 bytes (10 for MOV with a 64-bit immediate), and the byte-wide
// output port sends one byte a cycle while the sink holds ready high.
// Input beats are taken in any cycle the record queue (QueueDepth entries) has room, so
// the next instruction is classified while the previous one is still being sent; the
// first byte of an instruction passes through the queue entry, the shift register and the
// output register on its way out, and consecutive queued instructions leave without gaps.
`include "x86_64_subset_instruction_encoder_defines.svh"

module x86_64_subset_instruction_encoder #(
  parameter int unsigned QueueDepth = 2
) (
  input logic        clk_i,
  input logic        rst_ni,
  x64e_in_if.sink    inst_if,
  x64e_out_if.source byte_if
);
  import x64e_pkg::*;

  logic     push;
  logic     pop;
  enc_rec_t push_rec;
  enc_rec_t head;
  q_stat_t  q_stat;

  // Classify and build the byte record
  x64e_front u_front (
    .inst_if    (inst_if),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_rec_o (push_rec)
  );

  // Decouple classification from byte output
  x64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  // Serialize records into output beats
  x64e_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .byte_if  (byte_if)
  );

  `X64E_ASSERT_NEXT(a_accept_queued, clk_i, rst_ni, inst_if.valid && inst_if.ready, !q_stat.empty, "accepted beat not queued")
  `X64E_ASSERT_NOW(a_error_single, clk_i, rst_ni, byte_if.valid && byte_if.error, byte_if.last && byte_if.out_byte == 8'h00, "error beat not a single zero byte")
  `X64E_ASSERT_NEXT(a_no_gap, clk_i, rst_ni, byte_if.valid && byte_if.ready && !byte_if.last, byte_if.valid, "gap inside an instruction")

endmodule
